// ===== rtl/core/vmhc_pkg.sv =====
package vmhc_pkg;

  localparam int unsigned CmapSize = 11;
  localparam int unsigned SFrac = 16;
  localparam logic [16:0] SOne = 17'd65536;

  typedef logic [7:0] chan_t;

  // Heat colormap entry for one channel (0 red, 1 green, 2 blue).
  function automatic chan_t cmap(input logic [3:0] idx, input logic [1:0] ch);
    logic [23:0] e;
    begin
      unique case (idx)
        4'd0:    e = {8'd54,  8'd75,  8'd154};
        4'd1:    e = {8'd74,  8'd123, 8'd183};
        4'd2:    e = {8'd110, 8'd166, 8'd205};
        4'd3:    e = {8'd152, 8'd202, 8'd225};
        4'd4:    e = {8'd194, 8'd228, 8'd239};
        4'd5:    e = {8'd234, 8'd236, 8'd204};
        4'd6:    e = {8'd254, 8'd218, 8'd139};
        4'd7:    e = {8'd253, 8'd179, 8'd102};
        4'd8:    e = {8'd246, 8'd126, 8'd75};
        4'd9:    e = {8'd221, 8'd61,  8'd45};
        default: e = {8'd165, 8'd0,   8'd38};
      endcase
      unique case (ch)
        2'd0:    cmap = e[23:16];
        2'd1:    cmap = e[15:8];
        default: cmap = e[7:0];
      endcase
    end
  endfunction

  // Status passed from the serial root and divide units to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/core/vmhc_sqrt.sv =====
// Bit-serial integer square root: two radicand bits per cycle, one root bit out.
module vmhc_sqrt #(
  parameter int unsigned RW = 64,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] rad_i,
  output vmhc_pkg::unit_stat_t stat_o,
  output logic [QW-1:0] root_o
);
  localparam int unsigned CW = $clog2(QW + 1);

  logic [RW-1:0] rad_q;
  logic [QW+1:0] rem_q;
  logic [QW-1:0] root_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [QW+1:0] trial;
  logic [QW+1:0] diff;

  assign trial = {rem_q[QW-1:0], rad_q[RW-1 -: 2]};
  assign diff  = trial - {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q <= rad_q << 2;
        if (!diff[QW+1]) begin
          rem_q  <= diff;
          root_q <= {root_q[QW-2:0], 1'b1};
        end else begin
          rem_q  <= trial;
          root_q <= {root_q[QW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = root_q;
endmodule

// ===== rtl/core/vmhc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vmhc_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output vmhc_pkg::unit_stat_t stat_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   sh;
  logic [DW+1:0] sub;

  assign sh  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign sub = {1'b0, sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
        quo_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        if (!sub[DW+1]) begin
          rem_q <= sub[DW:0];
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= sh;
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/vector_magnitude_heatmap_colorizer_unit.sv =====
// Channel | Ports                                  | Direction
// input   | field_x/y/z_i, slice_end_i, valid_i    | in, stall_o back
// output  | red/green/blue_o, last_pixel_o, valid_o| out, stall_i back
//
// One request at a time: squares in ST_SQX, ST_SQY and ST_SQZ, serial square
// root of CW+1 root bits, serial divide of CW+16 quotient bits, then narrow
// multiplies and the colormap blend in ST_Q, ST_P1, ST_P2, ST_F and ST_MIX.
// The divide is skipped when the ratio saturates; a zero reference skips the
// divide and the multiplies. The serial root and divider take the most time.
// Reset restores the reference to 1.0 and clears the running maximum.
// A result held by stall_i keeps the next request waiting.
module vector_magnitude_heatmap_colorizer_unit #(
  parameter int unsigned COMPONENT_WIDTH = 24,
  parameter int unsigned FRACTION_BITS   = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [COMPONENT_WIDTH-1:0] field_x_i,
  input  logic [COMPONENT_WIDTH-1:0] field_y_i,
  input  logic [COMPONENT_WIDTH-1:0] field_z_i,
  input  logic                       slice_end_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [15:0]                red_o,
  output logic [15:0]                green_o,
  output logic [15:0]                blue_o,
  output logic                       last_pixel_o
);
  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned SQW = 2 * CW + 2;
  localparam int unsigned RW = SQW + (SQW % 2);
  localparam int unsigned QW = RW / 2;
  localparam int unsigned NW = CW + 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_ROOT, ST_DIV, ST_Q, ST_P1, ST_P2,
    ST_F, ST_MIX, ST_OUT
  } state_e;

  state_e state_q;
  logic [CW-1:0] x_q, y_q, z_q, ref_q, run_q;
  logic [RW-1:0] acc_q;
  logic          last_q;
  logic [17:0]   a_q;
  logic [16:0]   q_q, p_q;
  logic [16:0]   t_q;
  logic [3:0]    idx_q;
  logic [15:0]   r_q;
  logic          full_q;
  logic [15:0]   red_q, green_q, blue_q;
  logic          sq_go, dv_go;
  vmhc_pkg::unit_stat_t sq_st, dv_st;
  logic [QW-1:0] root;
  logic [NW-1:0] quo;
  logic [CW-1:0] sel, ab;
  logic [2*CW-1:0] sq;

  function automatic logic [CW-1:0] absv(input logic [CW-1:0] v);
    absv = v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    unique case (state_q)
      ST_SQX:  sel = x_q;
      ST_SQY:  sel = y_q;
      default: sel = z_q;
    endcase
    ab = absv(sel);
    sq = ab * ab;
  end

  logic [CW-1:0] mag_now;
  assign mag_now = root[CW-1:0];

  assign sq_go = (state_q == ST_SQZ);
  assign dv_go = (state_q == ST_ROOT) && sq_st.done && (ref_q != '0)
                 && ({1'b0, mag_now} < {ref_q, 1'b0});

  vmhc_sqrt #(.RW(RW), .QW(QW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .rad_i(acc_q + RW'(sq)),
    .stat_o(sq_st), .root_o(root)
  );

  // The divider starts in the cycle the root appears, so it takes the root directly.
  vmhc_div #(.NW(NW), .DW(CW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_go), .num_i({mag_now, 16'h0}),
    .den_i(ref_q), .stat_o(dv_st), .quo_o(quo)
  );

  function automatic logic [7:0] cmap_lo(input logic [3:0] i, input logic [1:0] c);
    cmap_lo = vmhc_pkg::cmap(i, c);
  endfunction
  function automatic logic [7:0] cmap_hi(input logic [3:0] i, input logic [1:0] c);
    cmap_hi = vmhc_pkg::cmap(i + 4'd1, c);
  endfunction

  // Blend of one channel: ((65536-r)*lo + r*hi) >> 8.
  function automatic logic [15:0] mix(input logic [3:0] i, input logic [15:0] r,
                                      input logic [1:0] ch);
    logic [24:0] s;
    s = ({1'b0, ~r} + 17'd1) * cmap_lo(i, ch) + r * cmap_hi(i, ch);
    mix = s[23:8];
  endfunction

  logic [16:0] s_sat;
  logic [35:0] aa;
  logic [33:0] qq;
  logic [33:0] pq;
  logic [20:0] f;
  assign s_sat = (quo > NW'(131072)) ? 17'h1ffff : quo[16:0];
  assign aa = a_q * a_q;
  assign qq = q_q * q_q;
  assign pq = p_q * q_q;
  assign f = t_q * 4'd11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ref_q   <= CW'(1) << FRACTION_BITS;
      run_q   <= '0;
      full_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (valid_i) begin
          x_q <= field_x_i; y_q <= field_y_i; z_q <= field_z_i;
          last_q <= slice_end_i;
          acc_q <= '0;
          state_q <= ST_SQX;
        end
        ST_SQX: begin acc_q <= RW'(sq); state_q <= ST_SQY; end
        ST_SQY: begin acc_q <= acc_q + RW'(sq); state_q <= ST_SQZ; end
        ST_SQZ: state_q <= ST_ROOT;
        ST_ROOT: if (sq_st.done) begin
          if (mag_now > run_q) run_q <= mag_now;
          if (ref_q == '0) begin
            t_q <= '0; state_q <= ST_F;
          end else if (!dv_go) begin
            a_q <= 18'd65536; state_q <= ST_Q;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: if (dv_st.done) begin
          a_q <= (s_sat >= vmhc_pkg::SOne) ? 18'(s_sat - vmhc_pkg::SOne)
                                           : 18'(vmhc_pkg::SOne - s_sat);
          state_q <= ST_Q;
        end
        ST_Q: begin
          q_q <= aa[32:16];
          state_q <= ST_P1;
        end
        ST_P1: begin p_q <= 17'(qq >> 16); state_q <= ST_P2; end
        ST_P2: begin
          t_q <= (pq[33:16] > 18'd65536) ? 17'd0 : 17'(18'd65536 - pq[33:16]);
          state_q <= ST_F;
        end
        ST_F: begin
          idx_q <= f[19:16];
          r_q <= f[15:0];
          full_q <= (t_q == '0);
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          if (full_q) begin
            red_q <= 16'd54 << 8; green_q <= 16'd75 << 8; blue_q <= 16'd154 << 8;
          end else if (idx_q >= 4'd10) begin
            red_q <= 16'd165 << 8; green_q <= 16'd0; blue_q <= 16'd38 << 8;
          end else begin
            red_q <= mix(idx_q, r_q, 2'd0);
            green_q <= mix(idx_q, r_q, 2'd1);
            blue_q <= mix(idx_q, r_q, 2'd2);
          end
          if (last_q) begin
            ref_q <= run_q;
            run_q <= '0;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: if (!stall_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign stall_o = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_OUT);
  assign red_o = red_q;
  assign green_o = green_q;
  assign blue_o = blue_q;
  assign last_pixel_o = last_q;
endmodule

// ===== rtl/core/vmhc_checker.sv =====
module vmhc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic stall_o,
  input logic valid_o,
  input logic stall_i,
  input logic [15:0] red_o
);
  // Held result keeps its red value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(red_o)) else $error("result dropped");
  // No request taken while a result is shown.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("request taken during output");
  // A request is followed by a stall.
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o) else $error("no stall after request");
endmodule

bind vector_magnitude_heatmap_colorizer_unit vmhc_checker u_chk (.*);

// ===== tb/vector_magnitude_heatmap_colorizer_unit_tb.sv =====
`timescale 1ns / 1ps

module vector_magnitude_heatmap_colorizer_unit_tb;

  localparam int unsigned CW = 24;
  localparam int unsigned FB = 12;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [CW-1:0] field_x_i = '0;
  logic [CW-1:0] field_y_i = '0;
  logic [CW-1:0] field_z_i = '0;
  logic slice_end_i = 1'b0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [15:0] red_o, green_o, blue_o;
  logic last_pixel_o;

  vector_magnitude_heatmap_colorizer_unit #(
    .COMPONENT_WIDTH(CW),
    .FRACTION_BITS(FB)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .field_x_i(field_x_i), .field_y_i(field_y_i), .field_z_i(field_z_i),
    .slice_end_i(slice_end_i), .valid_o(valid_o), .stall_i(stall_i),
    .red_o(red_o), .green_o(green_o), .blue_o(blue_o), .last_pixel_o(last_pixel_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  color_t expected_colors[$];
  logic [63:0] ref_mag;
  logic [63:0] slice_peak;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] abs_comp(input logic [CW-1:0] v);
    return v[CW-1] ? 64'((~v) + 1'b1) & ((64'd1 << CW) - 1) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Colors one cell against the current reference and advances slice state.
  function automatic color_t predict_color(input logic [CW-1:0] x, y, z,
                                           input logic last);
    color_t c;
    logic [63:0] ax, ay, az, mag, s, a, q, p, t, f, r, idx, lo, hi, one;
    one = 64'(vmhc_pkg::SOne);
    ax = abs_comp(x);
    ay = abs_comp(y);
    az = abs_comp(z);
    mag = int_sqrt(ax * ax + ay * ay + az * az) & ((64'd1 << CW) - 1);
    t = 0;
    if (ref_mag != 0) begin
      if (mag >= 2 * ref_mag) s = 2 * one;
      else s = (mag << 16) / ref_mag;
      if (s > 2 * one) s = 2 * one;
      a = (s >= one) ? s - one : one - s;
      q = (a * a) >> 16;
      p = (q * q) >> 16;
      p = (p * q) >> 16;
      if (p > one) p = one;
      t = one - p;
    end
    f = t * vmhc_pkg::CmapSize;
    idx = f >> 16;
    r = f & 64'hFFFF;
    if (t == 0) idx = 0;
    for (int ch = 0; ch < 3; ch++) begin
      logic [15:0] v;
      if (t == 0 || idx >= vmhc_pkg::CmapSize - 1) begin
        v = {vmhc_pkg::cmap(t == 0 ? 4'd0 : 4'd10, 2'(ch)), 8'd0};
      end else begin
        lo = 64'(vmhc_pkg::cmap(4'(idx), 2'(ch)));
        hi = 64'(vmhc_pkg::cmap(4'(idx + 1), 2'(ch)));
        v = 16'((((one - r) * lo + r * hi) >> 8));
      end
      if (ch == 0) c.red = v;
      else if (ch == 1) c.green = v;
      else c.blue = v;
    end
    c.last = last;
    if (mag > slice_peak) slice_peak = mag;
    if (last) begin
      ref_mag = slice_peak;
      slice_peak = 0;
    end
    return c;
  endfunction

  // Valid stays high after acceptance until the next request or a drain,
  // so back-to-back requests never assign valid_i twice in one step.
  task automatic send_cell(input logic [CW-1:0] x, y, z, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    field_x_i <= x;
    field_y_i <= y;
    field_z_i <= z;
    slice_end_i <= last;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_colors.push_back(predict_color(x, y, z, last));
    n_sent++;
  endtask

  // Receiver stall and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        color_t e;
        n_checked++;
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result r=%h g=%h b=%h last=%b", $time,
                   red_o, green_o, blue_o, last_pixel_o);
          n_errors++;
        end else begin
          e = expected_colors.pop_front();
          if (e.red !== red_o || e.green !== green_o || e.blue !== blue_o ||
              e.last !== last_pixel_o) begin
            $display("%0t: expected r=%h g=%h b=%h last=%b, actual r=%h g=%h b=%h last=%b",
                     $time, e.red, e.green, e.blue, e.last,
                     red_o, green_o, blue_o, last_pixel_o);
            n_errors++;
          end
        end
      end
      stall_i <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_comp(input int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(8192, 0)) - 4096);
      default: return CW'($signed($urandom_range(200000, 0)) - 100000);
    endcase
  endfunction

  task automatic test_directed();
    logic [CW-1:0] maxp, minn;
    maxp = {1'b0, {(CW-1){1'b1}}};
    minn = {1'b1, {(CW-1){1'b0}}};
    send_cell('0, '0, '0, 1'b0);                    // zero magnitude
    send_cell(CW'(4096), '0, '0, 1'b0);             // s exactly one
    send_cell(CW'(-4096), '0, '0, 1'b0);
    send_cell(CW'(2048), CW'(-2048), '0, 1'b0);
    send_cell(CW'(8192), '0, '0, 1'b0);             // s saturated at two
    send_cell(maxp, maxp, maxp, 1'b0);
    send_cell(minn, minn, minn, 1'b0);
    send_cell(maxp, minn, CW'(1), 1'b0);
    send_cell(CW'(1), CW'(-1), CW'(1), 1'b1);        // slice end with huge peak
    send_cell(CW'(100), '0, '0, 1'b1);               // tiny reference
    send_cell('0, '0, '0, 1'b1);                     // reference becomes zero
    send_cell(CW'(4096), CW'(4096), '0, 1'b0);       // zero reference
    send_cell('0, '0, '0, 1'b1);
    send_cell(CW'(4096), '0, '0, 1'b1);
    for (int i = 0; i <= 10; i++) begin
      send_cell(CW'(i * 410), '0, CW'(-i * 3), 1'b0);  // sweep the colormap
    end
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int mode;
    send_idle_pct = idle;
    stall_pct = stall;
    mode = $urandom_range(2, 0);
    for (int i = 0; i < count; i++) begin
      logic last;
      last = ($urandom_range(15, 0) == 0);
      if ($urandom_range(9, 0) == 0) mode = $urandom_range(2, 0);
      send_cell(rand_comp(mode), rand_comp(mode), rand_comp(mode), last);
    end
  endtask

  initial begin
    ref_mag = 64'd1 << FB;
    slice_peak = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350, 0, 0);
    // Hold off until the pipeline is empty before the next phase.
    drain();
    test_random(350, 72, 0);
    test_random(350, 0, 72);
    test_random(350, 20, 20);
    test_random(50, 0, 0);
    drain();
    stall_pct = 0;
    repeat (200) @(posedge clk_i);
    $display("Sent %0d cells over varied magnitudes, slice lengths and references;",
             n_sent);
    $display("checked %0d colors under sender gaps and receiver stalls.", n_checked);
    if (n_errors == 0 && expected_colors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
